// ----- rtl/pkcs7_pkg.sv -----
// Shared types and constants of the PKCS#7 pad/unpad engine.
package pkcs7_pkg;

  // Default geometry
  localparam int BLOCK_BYTES_DEF = 8;
  localparam int LENGTH_BITS_DEF = 16;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_MODE_IDX = 1'b0;

  // Mode register values
  localparam logic MODE_PAD   = 1'b0;
  localparam logic MODE_UNPAD = 1'b1;

  // Frame status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_LEN  = 3'd1,
    ST_BAD_PAD  = 3'd2,
    ST_INCONS   = 3'd3,
    ST_TOO_LONG = 3'd4
  } status_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_TAKE,
    OP_PAD_CALC,
    OP_PAD_BYTE,
    OP_UNP_CALC,
    OP_SCAN,
    OP_HELD_BYTE,
    OP_FINAL_EMPTY,
    OP_ERROR
  } dp_op_t;

  // Controller to datapath
  typedef struct packed {
    dp_op_t op;
    logic   clr;
  } pkcs7_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic load_ok;
    logic err;
    logic cnt_one;
    logic scan_last;
    logic keep_zero;
  } pkcs7_sts_t;

endpackage

// ----- rtl/pkcs7_if.sv -----
// Input and result channel interfaces of the PKCS#7 engine.
interface pkcs7_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       carries_byte;
  logic       last;

  modport source (output valid, data_byte, carries_byte, last, input ready);
  modport sink   (input valid, data_byte, carries_byte, last, output ready);
endinterface

interface pkcs7_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        out_valid;
  logic        frame_end;
  logic [2:0]  status;
  logic [15:0] out_length;

  modport source (output valid, out_byte, out_valid, frame_end, status, out_length,
                  input ready);
  modport sink   (input valid, out_byte, out_valid, frame_end, status, out_length,
                  output ready);
endinterface

// ----- rtl/pkcs7_dp.sv -----
// Datapath: holdback shift line, frame counters, checks and result register.
module pkcs7_dp #(
  parameter int BLOCK_BYTES = pkcs7_pkg::BLOCK_BYTES_DEF,
  parameter int LENGTH_BITS = pkcs7_pkg::LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   mode,
  input  logic                   cfg_clr,
  input  pkcs7_pkg::pkcs7_cmd_t  cmd,
  output pkcs7_pkg::pkcs7_sts_t  sts,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_carries_byte,
  output logic                   out_vld,
  input  logic                   out_rdy,
  output logic [7:0]             out_byte,
  output logic                   out_has_byte,
  output logic                   out_frame_end,
  output logic [2:0]             out_status,
  output logic [15:0]            out_length
);
  import pkcs7_pkg::*;

  localparam int CNT_W     = $clog2(BLOCK_BYTES + 1);
  localparam int IDX_W     = $clog2(BLOCK_BYTES);
  localparam int BC_W      = LENGTH_BITS + 1;
  localparam int SUM_W     = LENGTH_BITS + 2;
  localparam int LEN_EXT_W = (BC_W > 16) ? BC_W : 16;
  localparam logic [SUM_W-1:0] LEN_LIMIT  = {2'b00, {LENGTH_BITS{1'b1}}};
  localparam logic [CNT_W-1:0] B_CNT      = CNT_W'(BLOCK_BYTES);
  localparam logic [CNT_W-1:0] B_LAST_CNT = CNT_W'(BLOCK_BYTES - 1);
  localparam logic [IDX_W-1:0] B_LAST_IDX = IDX_W'(BLOCK_BYTES - 1);
  localparam logic [8:0]       B_9        = 9'(BLOCK_BYTES);

  // Holdback shift line, newest byte at the top entry
  logic [7:0]       held_r   [BLOCK_BYTES];
  logic [7:0]       held_nxt [BLOCK_BYTES];

  logic [CNT_W-1:0] held_cnt_r, held_cnt_nxt;
  logic [BC_W-1:0]  byte_cnt_r, byte_cnt_nxt;
  logic [IDX_W-1:0] blk_pos_r, blk_pos_nxt;
  status_t          status_r, status_nxt;
  logic [7:0]       pad_val_r, pad_val_nxt;
  logic [CNT_W-1:0] keep_r, keep_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [BC_W-1:0]  len_r, len_nxt;

  logic             out_vld_r, out_vld_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_has_r, out_has_nxt;
  logic             out_end_r, out_end_nxt;
  logic [2:0]       out_st_r, out_st_nxt;
  logic [15:0]      out_len_r, out_len_nxt;

  logic                 load_ok;
  logic                 held_full;
  logic                 cnt_one;
  logic [CNT_W-1:0]     pad_amt;
  logic [SUM_W-1:0]     pad_sum;
  logic [7:0]           p_byte;
  logic                 p_bad;
  logic                 len_bad;
  logic [CNT_W-1:0]     keep_amt;
  logic [BC_W-1:0]      unp_len;
  logic                 mismatch;
  logic [LEN_EXT_W-1:0] len_ext;
  logic [15:0]          len16;

  // Derived values
  assign load_ok   = !out_vld_r || out_rdy;
  assign held_full = (held_cnt_r == B_CNT);
  assign cnt_one   = (cnt_r == CNT_W'(1));
  assign pad_amt   = B_CNT - CNT_W'(blk_pos_r);
  assign pad_sum   = SUM_W'(byte_cnt_r) + SUM_W'(pad_amt);
  assign p_byte    = held_r[BLOCK_BYTES-1];
  assign p_bad     = (p_byte == 8'd0) || ({1'b0, p_byte} > B_9);
  assign len_bad   = (byte_cnt_r == '0) || (blk_pos_r != '0) || !held_full;
  assign keep_amt  = CNT_W'(B_9 - {1'b0, p_byte});
  assign unp_len   = byte_cnt_r - BC_W'(p_byte);
  assign mismatch  = (held_r[0] != pad_val_r);
  assign len_ext   = LEN_EXT_W'(len_r);
  assign len16     = len_ext[15:0];

  // Status to the controller
  assign sts.load_ok   = load_ok;
  assign sts.err       = (status_r != ST_OK);
  assign sts.cnt_one   = cnt_one;
  assign sts.scan_last = (cnt_r == B_LAST_CNT);
  assign sts.keep_zero = (keep_r == '0);

  // Next-state logic per operation
  always_comb begin
    held_nxt     = held_r;
    held_cnt_nxt = held_cnt_r;
    byte_cnt_nxt = byte_cnt_r;
    blk_pos_nxt  = blk_pos_r;
    status_nxt   = status_r;
    pad_val_nxt  = pad_val_r;
    keep_nxt     = keep_r;
    cnt_nxt      = cnt_r;
    len_nxt      = len_r;
    out_vld_nxt  = out_vld_r && !out_rdy;
    out_byte_nxt = out_byte_r;
    out_has_nxt  = out_has_r;
    out_end_nxt  = out_end_r;
    out_st_nxt   = out_st_r;
    out_len_nxt  = out_len_r;

    unique case (cmd.op)
      OP_TAKE: begin
        if (in_carries_byte) begin
          // saturate at 2^LENGTH_BITS, the over-limit mark
          if (!byte_cnt_r[LENGTH_BITS]) begin
            byte_cnt_nxt = byte_cnt_r + BC_W'(1);
          end
          blk_pos_nxt = (blk_pos_r == B_LAST_IDX) ? '0 : blk_pos_r + IDX_W'(1);
          if (mode == MODE_PAD) begin
            out_vld_nxt  = 1'b1;
            out_byte_nxt = in_data_byte;
            out_has_nxt  = 1'b1;
            out_end_nxt  = 1'b0;
            out_st_nxt   = ST_OK;
            out_len_nxt  = '0;
          end else begin
            // full line: oldest byte leaves as it shifts out
            if (held_full) begin
              out_vld_nxt  = 1'b1;
              out_byte_nxt = held_r[0];
              out_has_nxt  = 1'b1;
              out_end_nxt  = 1'b0;
              out_st_nxt   = ST_OK;
              out_len_nxt  = '0;
            end else begin
              held_cnt_nxt = held_cnt_r + CNT_W'(1);
            end
            for (int i = 0; i < BLOCK_BYTES - 1; i++) begin
              held_nxt[i] = held_r[i+1];
            end
            held_nxt[BLOCK_BYTES-1] = in_data_byte;
          end
        end
      end

      OP_PAD_CALC: begin
        status_nxt  = (byte_cnt_r[LENGTH_BITS] || (pad_sum > LEN_LIMIT)) ? ST_TOO_LONG
                                                                        : ST_OK;
        len_nxt     = pad_sum[BC_W-1:0];
        pad_val_nxt = 8'(pad_amt);
        cnt_nxt     = pad_amt;
      end

      OP_PAD_BYTE: begin
        out_vld_nxt  = 1'b1;
        out_byte_nxt = pad_val_r;
        out_has_nxt  = 1'b1;
        out_end_nxt  = cnt_one;
        out_st_nxt   = ST_OK;
        out_len_nxt  = cnt_one ? len16 : '0;
        cnt_nxt      = cnt_r - CNT_W'(1);
      end

      OP_UNP_CALC: begin
        // checks in order: too long, length, pad value
        priority if (byte_cnt_r[LENGTH_BITS]) begin
          status_nxt = ST_TOO_LONG;
        end else if (len_bad) begin
          status_nxt = ST_BAD_LEN;
        end else if (p_bad) begin
          status_nxt = ST_BAD_PAD;
        end else begin
          status_nxt = ST_OK;
        end
        pad_val_nxt = p_byte;
        keep_nxt    = keep_amt;
        len_nxt     = unp_len;
        cnt_nxt     = '0;
      end

      OP_SCAN: begin
        // rotate the line once; entries at or past keep must equal the pad value
        if ((cnt_r >= keep_r) && mismatch && (status_r == ST_OK)) begin
          status_nxt = ST_INCONS;
        end
        for (int i = 0; i < BLOCK_BYTES - 1; i++) begin
          held_nxt[i] = held_r[i+1];
        end
        held_nxt[BLOCK_BYTES-1] = held_r[0];
        cnt_nxt = (cnt_r == B_LAST_CNT) ? keep_r : cnt_r + CNT_W'(1);
      end

      OP_HELD_BYTE: begin
        out_vld_nxt  = 1'b1;
        out_byte_nxt = held_r[0];
        out_has_nxt  = 1'b1;
        out_end_nxt  = cnt_one;
        out_st_nxt   = ST_OK;
        out_len_nxt  = cnt_one ? len16 : '0;
        for (int i = 0; i < BLOCK_BYTES - 1; i++) begin
          held_nxt[i] = held_r[i+1];
        end
        cnt_nxt = cnt_r - CNT_W'(1);
      end

      OP_FINAL_EMPTY: begin
        out_vld_nxt  = 1'b1;
        out_byte_nxt = '0;
        out_has_nxt  = 1'b0;
        out_end_nxt  = 1'b1;
        out_st_nxt   = ST_OK;
        out_len_nxt  = len16;
      end

      OP_ERROR: begin
        out_vld_nxt  = 1'b1;
        out_byte_nxt = '0;
        out_has_nxt  = 1'b0;
        out_end_nxt  = 1'b1;
        out_st_nxt   = status_r;
        out_len_nxt  = '0;
      end

      OP_NONE: begin
      end

      default: begin
      end
    endcase

    // frame end or mode write drops the frame state
    if (cmd.clr || cfg_clr) begin
      held_cnt_nxt = '0;
      byte_cnt_nxt = '0;
      blk_pos_nxt  = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= '0;
      byte_cnt_r <= '0;
      blk_pos_r  <= '0;
      status_r   <= ST_OK;
      cnt_r      <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      held_cnt_r <= held_cnt_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      blk_pos_r  <= blk_pos_nxt;
      status_r   <= status_nxt;
      cnt_r      <= cnt_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    held_r     <= held_nxt;
    pad_val_r  <= pad_val_nxt;
    keep_r     <= keep_nxt;
    len_r      <= len_nxt;
    out_byte_r <= out_byte_nxt;
    out_has_r  <= out_has_nxt;
    out_end_r  <= out_end_nxt;
    out_st_r   <= out_st_nxt;
    out_len_r  <= out_len_nxt;
  end

  assign out_vld       = out_vld_r;
  assign out_byte      = out_byte_r;
  assign out_has_byte  = out_has_r;
  assign out_frame_end = out_end_r;
  assign out_status    = out_st_r;
  assign out_length    = out_len_r;

endmodule

// ----- rtl/pkcs7_ctrl.sv -----
// Controller: sequences byte intake, frame-end checks and result emission.
module pkcs7_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  mode,
  input  logic                  in_valid,
  input  logic                  in_last,
  output logic                  in_ready,
  input  pkcs7_pkg::pkcs7_sts_t sts,
  output pkcs7_pkg::pkcs7_cmd_t cmd
);
  import pkcs7_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD_CALC,
    S_PAD_EMIT,
    S_UNP_CALC,
    S_UNP_SCAN,
    S_UNP_EMIT
  } state_t;

  state_t state_r, state_nxt;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd.op    = OP_NONE;
    cmd.clr   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = sts.load_ok;
        if (in_valid && sts.load_ok) begin
          cmd.op = OP_TAKE;
          if (in_last) begin
            state_nxt = (mode == MODE_UNPAD) ? S_UNP_CALC : S_PAD_CALC;
          end
        end
      end

      S_PAD_CALC: begin
        cmd.op    = OP_PAD_CALC;
        state_nxt = S_PAD_EMIT;
      end

      S_PAD_EMIT: begin
        if (sts.load_ok) begin
          if (sts.err) begin
            cmd.op    = OP_ERROR;
            cmd.clr   = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.op = OP_PAD_BYTE;
            if (sts.cnt_one) begin
              cmd.clr   = 1'b1;
              state_nxt = S_IDLE;
            end
          end
        end
      end

      S_UNP_CALC: begin
        cmd.op    = OP_UNP_CALC;
        state_nxt = S_UNP_SCAN;
      end

      // one pad-byte compare per cycle, stop early on error
      S_UNP_SCAN: begin
        if (sts.err) begin
          state_nxt = S_UNP_EMIT;
        end else begin
          cmd.op = OP_SCAN;
          if (sts.scan_last) begin
            state_nxt = S_UNP_EMIT;
          end
        end
      end

      S_UNP_EMIT: begin
        if (sts.load_ok) begin
          priority if (sts.err) begin
            cmd.op    = OP_ERROR;
            cmd.clr   = 1'b1;
            state_nxt = S_IDLE;
          end else if (sts.keep_zero) begin
            cmd.op    = OP_FINAL_EMPTY;
            cmd.clr   = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.op = OP_HELD_BYTE;
            if (sts.cnt_one) begin
              cmd.clr   = 1'b1;
              state_nxt = S_IDLE;
            end
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/pkcs7_pad_unpad_engine_core.sv -----
// Top level of the PKCS#7 pad/unpad engine: configuration port and unit wiring.
// Byte-stream PKCS#7 engine. mode 0 passes bytes through and appends P bytes of value
// P at each frame end, reporting the padded length (or a too-long error status); mode 1
// holds back the newest BLOCK_BYTES bytes, checks the final block and emits its data
// bytes (or an error status) at frame end. Every item that is not a frame end transfers
// whenever the single output register is free or being drained. The item marked last
// holds in_ready low while the controller finishes the frame: pad mode passes through a
// calculation state, then emits the pad bytes (1 to BLOCK_BYTES) or the error; unpad
// mode passes through a check state, rotates the holdback shift line past the pad-byte
// comparator (stopping early on error), then emits the data bytes or the error. Output
// back-pressure stalls emission. Writing mode (offset 0) drops any frame in progress;
// write it only while the engine is idle.
module pkcs7_pad_unpad_engine_core #(
  parameter int BLOCK_BYTES = pkcs7_pkg::BLOCK_BYTES_DEF,
  parameter int LENGTH_BITS = pkcs7_pkg::LENGTH_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  pkcs7_in_if.sink                        in_chan,
  pkcs7_out_if.source                     out_chan,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pkcs7_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pkcs7_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pkcs7_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import pkcs7_pkg::*;

  logic       mode_r;
  logic       reg_sel;
  logic       mode_wr;
  pkcs7_cmd_t cmd;
  pkcs7_sts_t sts;

  // Register decode, one 32-bit word per register
  assign reg_sel = (paddr[CFG_ADDR_W-1] == REG_MODE_IDX);
  assign mode_wr = psel && penable && pwrite && reg_sel;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(CFG_DATA_W-1){1'b0}}, mode_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PAD;
    end else if (mode_wr) begin
      mode_r <= pwdata[0];
    end
  end

  pkcs7_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .mode     (mode_r),
    .in_valid (in_chan.valid),
    .in_last  (in_chan.last),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pkcs7_dp #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .mode            (mode_r),
    .cfg_clr         (mode_wr),
    .cmd             (cmd),
    .sts             (sts),
    .in_data_byte    (in_chan.data_byte),
    .in_carries_byte (in_chan.carries_byte),
    .out_vld         (out_chan.valid),
    .out_rdy         (out_chan.ready),
    .out_byte        (out_chan.out_byte),
    .out_has_byte    (out_chan.out_valid),
    .out_frame_end   (out_chan.frame_end),
    .out_status      (out_chan.status),
    .out_length      (out_chan.out_length)
  );

endmodule

// ----- rtl/pkcs7_chk.sv -----
// Port-level checker for the PKCS#7 engine, bound to the top level.
module pkcs7_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_vld,
  input logic        out_rdy,
  input logic [7:0]  out_byte,
  input logic        out_has_byte,
  input logic        frame_end,
  input logic [2:0]  status,
  input logic [15:0] out_length
);
  import pkcs7_pkg::*;

  // A stalled result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && !out_rdy |=> out_vld &&
      $stable({out_byte, out_has_byte, frame_end, status, out_length}))
    else $error("result changed while stalled");

  // Frame end transfer blocks intake for at least the next cycle
  a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("intake open right after frame end");

  // Error results carry no byte and no length and end the frame
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && (status != ST_OK) |-> !out_has_byte && frame_end && (out_length == 16'd0))
    else $error("malformed error result");

  // Mid-frame results are plain ok bytes
  a_mid_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && !frame_end |-> out_has_byte && (status == ST_OK) && (out_length == 16'd0))
    else $error("malformed mid-frame result");

endmodule

bind pkcs7_pad_unpad_engine_core pkcs7_chk u_pkcs7_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .in_last      (in_chan.last),
  .out_vld      (out_chan.valid),
  .out_rdy      (out_chan.ready),
  .out_byte     (out_chan.out_byte),
  .out_has_byte (out_chan.out_valid),
  .frame_end    (out_chan.frame_end),
  .status       (out_chan.status),
  .out_length   (out_chan.out_length)
);

// ----- tb/sv/pkcs7_pad_unpad_engine_core_tb.sv -----
// Self-checking testbench of the PKCS#7 pad/unpad engine core.
module pkcs7_pad_unpad_engine_core_tb;
  import pkcs7_pkg::*;

  localparam int BLK           = BLOCK_BYTES_DEF;
  localparam int LEN_MAX       = (1 << LENGTH_BITS_DEF) - 1;
  localparam int NUM_REGS      = 1;
  localparam logic [CFG_ADDR_W-1:0] MODE_ADDR  = CFG_ADDR_W'(4 * REG_MODE_IDX);
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR = CFG_ADDR_W'(4 * NUM_REGS);
  localparam int SETTLE_CYCLES = 3 * BLK + 8;
  localparam int RANDOM_ITEMS  = 330;
  localparam int NUM_PHASES    = 6;
  localparam int IDLE_PCT      = 27;
  localparam int HOLD_CYCLES   = 200;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [7:0]  data;
    logic        carries;
    logic        frame_end;
    status_t     status;
    logic [15:0] len;
  } pkcs7_result_t;

  // Frame predictor plus the queue of results still owed by the engine
  class pkcs7_frame_scoreboard;
    pkcs7_result_t awaited_out[$];
    logic          mode;
    logic [7:0]    held[BLK];
    int            held_n;
    int unsigned   frame_len;
    int            errors;

    function new();
      mode      = MODE_PAD;
      held_n    = 0;
      frame_len = 0;
      errors    = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function void owe(logic [7:0] d, logic v, logic fe, status_t st, logic [15:0] len);
      pkcs7_result_t r;
      r.data      = d;
      r.carries   = v;
      r.frame_end = fe;
      r.status    = st;
      r.len       = len;
      awaited_out.push_back(r);
    endfunction

    function void write_reg(int idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_MODE_IDX) begin
        mode      = val[0];
        held_n    = 0;
        frame_len = 0;
      end
    endfunction

    // pad mode frame end: P bytes of value P, or a too-long marker
    function void close_pad_frame();
      int unsigned pad;
      int i;
      pad = BLK - (frame_len % BLK);
      if (frame_len + pad > LEN_MAX) begin
        owe('0, 1'b0, 1'b1, ST_TOO_LONG, '0);
      end else begin
        for (i = 0; i < pad; i++) begin
          owe(8'(pad), 1'b1, i == pad - 1, ST_OK, (i == pad - 1) ? 16'(frame_len + pad) : '0);
        end
      end
    endfunction

    // unpad mode frame end: check the held block, then release its data bytes
    function void close_unpad_frame();
      status_t st;
      int unsigned p, keep;
      int i;
      st = ST_OK;
      p  = 0;
      if (frame_len > LEN_MAX) begin
        st = ST_TOO_LONG;
      end else if (frame_len == 0 || (frame_len % BLK) != 0 || held_n != BLK) begin
        st = ST_BAD_LEN;
      end else begin
        p = held[BLK-1];
        if (p == 0 || p > BLK) begin
          st = ST_BAD_PAD;
        end else begin
          for (i = BLK - p; i < BLK; i++) begin
            if (held[i] != p) st = ST_INCONS;
          end
        end
      end
      if (st != ST_OK) begin
        owe('0, 1'b0, 1'b1, st, '0);
      end else begin
        keep = BLK - p;
        if (keep == 0) owe('0, 1'b0, 1'b1, ST_OK, 16'(frame_len - p));
        for (i = 0; i < keep; i++) begin
          owe(held[i], 1'b1, i == keep - 1, ST_OK, (i == keep - 1) ? 16'(frame_len - p) : '0);
        end
      end
    endfunction

    // one accepted input transfer
    function void take_input(logic [7:0] d, logic has, logic lst);
      int i;
      if (has) begin
        if (frame_len <= LEN_MAX) frame_len++;
        if (mode == MODE_PAD) begin
          owe(d, 1'b1, 1'b0, ST_OK, '0);
        end else begin
          if (held_n >= BLK) begin
            owe(held[0], 1'b1, 1'b0, ST_OK, '0);
            for (i = 0; i < BLK - 1; i++) held[i] = held[i+1];
            held_n = BLK - 1;
          end
          held[held_n] = d;
          held_n++;
        end
      end
      if (lst) begin
        if (mode == MODE_PAD) close_pad_frame();
        else close_unpad_frame();
        held_n    = 0;
        frame_len = 0;
      end
    endfunction

    task check_result(pkcs7_result_t got);
      pkcs7_result_t want;
      if (awaited_out.size() == 0) begin
        report($sformatf("unexpected result byte=%0h vld=%0b end=%0b st=%0d",
                         got.data, got.carries, got.frame_end, got.status));
        return;
      end
      want = awaited_out.pop_front();
      if (got.data !== want.data)
        report($sformatf("out_byte %0h, want %0h", got.data, want.data));
      if (got.carries !== want.carries)
        report($sformatf("out_valid %0b, want %0b", got.carries, want.carries));
      if (got.frame_end !== want.frame_end)
        report($sformatf("frame_end %0b, want %0b", got.frame_end, want.frame_end));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.len !== want.len)
        report($sformatf("out_length %0d, want %0d", got.len, want.len));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  bit idle_on;
  int hold_request;
  int items_sent;
  pkcs7_frame_scoreboard sb = new();

  pkcs7_in_if  in_chan();
  pkcs7_out_if out_chan();

  pkcs7_pad_unpad_engine_core u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: random ready, long hold-off on request, check at negedge
  initial begin : result_sink
    int hold_left;
    pkcs7_result_t got;
    hold_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else begin
        out_chan.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
      end
      @(negedge clk);
      if (out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
        got.data      = out_chan.out_byte;
        got.carries   = out_chan.out_valid;
        got.frame_end = out_chan.frame_end;
        got.status    = status_t'(out_chan.status);
        got.len       = out_chan.out_length;
        sb.check_result(got);
      end
    end
  end

  // one input transfer, with random idle cycles ahead of it
  task send_item(input logic [7:0] d, input logic has, input logic lst);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      @(posedge clk);
      in_chan.valid <= 1'b0;
    end
    @(posedge clk);
    in_chan.valid        <= 1'b1;
    in_chan.data_byte    <= d;
    in_chan.carries_byte <= has;
    in_chan.last         <= lst;
    @(negedge clk);
    while (in_chan.ready !== 1'b1) @(negedge clk);
    sb.take_input(d, has, lst);
    if (has || lst) items_sent++;
  endtask

  // frame of bytes, with stray empty items; end on the last byte or on an empty item
  task send_frame(input byte_q_t bytes_q, input bit split_end);
    int i;
    for (i = 0; i < bytes_q.size(); i++) begin
      if ($urandom_range(99) < 8) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(bytes_q[i], 1'b1, !split_end && i == bytes_q.size() - 1);
    end
    if (split_end || bytes_q.size() == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task send_long_frame(input int n, input bit split_end);
    int i;
    for (i = 0; i < n; i++) send_item(8'($urandom_range(255)), 1'b1, !split_end && i == n - 1);
    if (split_end) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  function automatic byte_q_t random_bytes(int n);
    byte_q_t q;
    int i;
    for (i = 0; i < n; i++) q.push_back(8'($urandom_range(255)));
    return q;
  endfunction

  function automatic byte_q_t pad_frame_bytes();
    int n;
    n = ($urandom_range(99) < 85) ? $urandom_range(0, 2 * BLK + 3)
                                  : $urandom_range(3 * BLK, 6 * BLK);
    return random_bytes(n);
  endfunction

  // mostly well-padded frames; the rest carry one kind of padding fault
  function automatic byte_q_t unpad_frame_bytes();
    byte_q_t q;
    int kind, dlen, p, n, i, j;
    kind = $urandom_range(99);
    if (kind >= 88) begin
      p    = $urandom_range(2, BLK);
      dlen = BLK * $urandom_range(0, 2) + BLK - p;
    end else begin
      dlen = $urandom_range(0, 2 * BLK + 2);
      p    = BLK - (dlen % BLK);
    end
    q = random_bytes(dlen);
    for (i = 0; i < p; i++) q.push_back(8'(p));
    if (kind >= 88) begin
      // one pad byte other than the last differs
      j    = $urandom_range(q.size() - p, q.size() - 2);
      q[j] = q[j] ^ 8'($urandom_range(1, 255));
    end else if (kind >= 80) begin
      // pad value zero or above the block size
      q[q.size()-1] = $urandom_range(1) ? 8'h00 : 8'($urandom_range(BLK + 1, 255));
    end else if (kind >= 72) begin
      // length zero or not a block multiple
      n = $urandom_range(0, 3 * BLK);
      if (n != 0 && n % BLK == 0) n--;
      q = random_bytes(n);
    end
    return q;
  endfunction

  // drop valid, wait for every owed result, then let the engine settle
  task wait_idle();
    @(posedge clk);
    in_chan.valid <= 1'b0;
    while (sb.awaited_out.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (pready !== 1'b1) @(negedge clk);
    sb.write_reg(int'(addr) >> 2, data);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task cfg_check_mode();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= MODE_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (pready !== 1'b1) @(negedge clk);
    if (prdata !== CFG_DATA_W'(sb.mode))
      sb.report($sformatf("mode readback %0h, want %0h", prdata, sb.mode));
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task set_mode(input logic m);
    logic [CFG_DATA_W-1:0] val;
    val = $urandom();
    if ($urandom_range(1)) val = '0;
    val[0] = m;
    cfg_write(MODE_ADDR, val);
    cfg_check_mode();
  endtask

  initial begin : stimulus
    int ph, target;
    byte_q_t q;
    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.data_byte    <= '0;
    in_chan.carries_byte <= 1'b0;
    in_chan.last         <= 1'b0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    idle_on      = 1'b1;
    hold_request = 0;
    items_sent   = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, pad mode out of reset
    cfg_check_mode();
    send_item(8'h5A, 1'b0, 1'b1);                 // empty frame -> one block of padding
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b0);                 // empty item gives nothing
    send_item(8'hFF, 1'b1, 1'b1);

    // Directed, unpad mode
    wait_idle();
    set_mode(MODE_UNPAD);
    send_long_frame(0, 1'b0);
    for (int i = 0; i < BLK; i++) send_item(8'(BLK), 1'b1, i == BLK - 1);  // all pad
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);                 // short frame -> bad length
    send_item(8'hC3, 1'b0, 1'b1);                 // empty frame -> bad length

    // Random phases, alternating mode
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      if (ph == 3) begin
        cfg_write(SPARE_ADDR, $urandom());        // unmapped offset, ignored
        cfg_check_mode();
      end
      set_mode(ph % 2 ? MODE_UNPAD : MODE_PAD);
      @(negedge clk);
      idle_on = (ph != 2);
      if (ph == 1 || ph == 4) hold_request = HOLD_CYCLES;
      target = items_sent + RANDOM_ITEMS / NUM_PHASES;
      while (items_sent < target) begin
        q = (ph % 2) ? unpad_frame_bytes() : pad_frame_bytes();
        send_frame(q, $urandom_range(99) < 35);
      end
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
